@@ rtl/psc_pkg.sv @@
// Shared types and constants for the pressure compensation datapath.
`default_nettype none

package psc_pkg;

    localparam int ADC_W     = 10;
    localparam int WORD_W    = 16;
    localparam int FRAC_BITS = 22;
    localparam int SUM_W     = 40;
    localparam int Q4_W      = 14;
    localparam int KPA_W     = 11;
    localparam int SCL_W     = 21;

    localparam int A0_SHIFT = FRAC_BITS - 3;
    localparam int B1_SHIFT = FRAC_BITS - 13;
    localparam int B2_SHIFT = FRAC_BITS - 14;

    localparam int PCOMP_MAX = 1023;
    localparam int KPA_LOW   = 50;
    localparam int KPA_HIGH  = 115;

    localparam logic [SUM_W-1:0] PCOMP_TOP = SUM_W'(PCOMP_MAX) << FRAC_BITS;
    localparam logic [Q4_W-1:0]  Q4_MAX    = Q4_W'(PCOMP_MAX << 4);
    localparam logic [KPA_W-1:0] KPA_BASE  = KPA_W'(KPA_LOW * 16);
    localparam logic [KPA_W-1:0] KPA_TOP   = KPA_W'(KPA_HIGH * 16);
    localparam logic [SCL_W-1:0] KPA_SPAN  = SCL_W'(KPA_HIGH - KPA_LOW);
    localparam logic [SCL_W-1:0] ROUND_ADD = SCL_W'(PCOMP_MAX / 2);

    typedef enum logic [1:0] {
        REG_A0  = 2'd0,
        REG_B1  = 2'd1,
        REG_B2  = 2'd2,
        REG_C12 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [WORD_W-1:0] a0;
        logic signed [WORD_W-1:0] b1;
        logic signed [WORD_W-1:0] b2;
        logic signed [WORD_W-1:0] c12;
    } t_coefs;

    typedef struct packed {
        logic [WORD_W-1:0] pressure_word;
        logic [WORD_W-1:0] temperature_word;
    } t_in_req;

    typedef struct packed {
        logic [KPA_W-1:0] pressure_sixteenths_kpa;
        logic [Q4_W-1:0]  pcomp_q4;
        logic             clamped;
    } t_out_req;

    typedef struct packed {
        logic [Q4_W-1:0] pcomp_q4;
        logic            clamped;
    } t_poly_res;

endpackage

`default_nettype wire

@@ rtl/psc_cfg.sv @@
// Calibration coefficient register file.
`default_nettype none

module psc_cfg
    import psc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_reg_idx          i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    output t_coefs                 o_coefs
);

    t_coefs r_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_A0:  r_coefs.a0  <= i_cfg_data;
                REG_B1:  r_coefs.b1  <= i_cfg_data;
                REG_B2:  r_coefs.b2  <= i_cfg_data;
                REG_C12: r_coefs.c12 <= i_cfg_data;
                default: r_coefs     <= r_coefs;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/psc_poly.sv @@
// Polynomial stages: products, partial sum, final sum with clamp.
`default_nettype none

module psc_poly
    import psc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_coefs  i_coefs,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_in_req i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_poly_res    o_data
);

    localparam int PA_W  = ADC_W + 1;
    localparam int MB_W  = WORD_W + PA_W;
    localparam int C12_W = WORD_W - 2;
    localparam int MC_W  = C12_W + PA_W;
    localparam int M4_W  = MC_W + ADC_W;

    // stage 1: single products
    logic                   r_v1;
    logic [ADC_W-1:0]       r_padc1;
    logic signed [MB_W-1:0] r_mb1;
    logic signed [MB_W-1:0] r_mb2;
    logic signed [MC_W-1:0] r_mc;
    // stage 2: cross product and partial sum
    logic                    r_v2;
    logic signed [M4_W-1:0]  r_m4;
    logic signed [SUM_W-1:0] r_part;
    // stage 3: result
    logic      r_v3;
    t_poly_res r_res;

    logic rdy1, rdy2, rdy3;

    logic signed [PA_W-1:0]  padc_s;
    logic signed [PA_W-1:0]  tadc_s;
    logic signed [PA_W-1:0]  padc1_s;
    logic signed [C12_W-1:0] c12;
    logic signed [SUM_W-1:0] sum;
    t_poly_res               n_res;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_res;

    always_comb begin
        padc_s  = signed'({1'b0, i_data.pressure_word[WORD_W-1 -: ADC_W]});
        tadc_s  = signed'({1'b0, i_data.temperature_word[WORD_W-1 -: ADC_W]});
        padc1_s = signed'({1'b0, r_padc1});
        c12     = i_coefs.c12[WORD_W-1:2];
    end

    always_comb begin
        sum = r_part + SUM_W'(r_m4);
        if (sum < 0) begin
            n_res.pcomp_q4 = '0;
            n_res.clamped  = 1'b1;
        end else if (sum > signed'(PCOMP_TOP)) begin
            n_res.pcomp_q4 = Q4_MAX;
            n_res.clamped  = 1'b1;
        end else begin
            n_res.pcomp_q4 = sum[FRAC_BITS-4 +: Q4_W];
            n_res.clamped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_padc1 <= i_data.pressure_word[WORD_W-1 -: ADC_W];
            r_mb1   <= MB_W'(i_coefs.b1) * MB_W'(padc_s);
            r_mb2   <= MB_W'(i_coefs.b2) * MB_W'(tadc_s);
            r_mc    <= MC_W'(c12) * MC_W'(tadc_s);
        end
        if (rdy2) begin
            r_m4   <= M4_W'(r_mc) * M4_W'(padc1_s);
            r_part <= (SUM_W'(i_coefs.a0) <<< A0_SHIFT)
                    + (SUM_W'(r_mb1) <<< B1_SHIFT)
                    + (SUM_W'(r_mb2) <<< B2_SHIFT);
        end
        if (rdy3) begin
            r_res <= n_res;
        end
    end

    a_clamp_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_res.clamped |-> (r_res.pcomp_q4 == '0 || r_res.pcomp_q4 == Q4_MAX))
        else $error("clamped result not at a range limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready |=> r_v3 && $stable(r_res))
        else $error("stage 3 result lost during stall");

endmodule

`default_nettype wire

@@ rtl/psc_scale.sv @@
// Scaling stages: map the clamped count onto 50..115 kPa in 1/16 kPa.
`default_nettype none

module psc_scale
    import psc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_poly_res i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_req       o_data
);

    localparam int QH_W = SCL_W - 10;

    logic             r_v4;
    logic [SCL_W-1:0] r_x;
    t_poly_res        r_res4;
    logic             r_v5;
    t_out_req         r_out;

    logic rdy4, rdy5;

    logic [SCL_W-1:0] n_x;
    logic [QH_W-1:0]  q0;
    logic [QH_W:0]    rem;
    logic [1:0]       rem_hi;
    logic [10:0]      rem_fix;
    logic [QH_W-1:0]  quot;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;
    assign o_valid = r_v5;
    assign o_data  = r_out;

    // q4 * span + half divisor, span being 65
    assign n_x = (SCL_W'(i_data.pcomp_q4) * KPA_SPAN) + ROUND_ADD;

    // divide by 1023: 1024 q0 = 1023 q0 + q0, fold the carry back once more
    always_comb begin
        q0      = r_x[SCL_W-1:10];
        rem     = {2'b00, r_x[9:0]} + (QH_W+1)'(q0);
        rem_hi  = rem[11:10];
        rem_fix = {1'b0, rem[9:0]} + 11'(rem_hi);
        quot    = q0 + QH_W'(rem_hi) + QH_W'(rem_fix >= 11'(PCOMP_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_x    <= n_x;
            r_res4 <= i_data;
        end
        if (rdy5) begin
            r_out.pressure_sixteenths_kpa <= KPA_BASE + KPA_W'(quot);
            r_out.pcomp_q4                <= r_res4.pcomp_q4;
            r_out.clamped                 <= r_res4.clamped;
        end
    end

    a_kpa_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_out.pressure_sixteenths_kpa >= KPA_BASE
               && r_out.pressure_sixteenths_kpa <= KPA_TOP))
        else $error("scaled pressure out of range");

    a_kpa_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && r_out.pcomp_q4 == '0 |-> r_out.pressure_sixteenths_kpa == KPA_BASE)
        else $error("zero count not at low end");

    a_kpa_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && r_out.pcomp_q4 == Q4_MAX |-> r_out.pressure_sixteenths_kpa == KPA_TOP)
        else $error("full count not at high end");

endmodule

`default_nettype wire

@@ rtl/pressure_sensor_compensation_top.sv @@
// Barometric pressure compensation: top level.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one request carries a
// raw pressure word and a raw temperature word; the ADC counts sit in bits
// 15..6 of each. Output channel (o_out_valid / i_out_ready / o_out_data):
// compensated pressure in 1/16 kPa, the clamped count with 4 fraction bits and
// the clamp flag. Coefficients a0, b1, b2, c12 are written on the cfg channel
// (index 0..3), which is always ready; write them only while the block is idle.
//
// Five register stages: three products, cross product and partial sum, final
// sum and clamp, scale multiply, divide by 1023 into the output register.
// One request is taken every cycle while the receiver keeps up. The throughput
// limit is the output register: each stage advances when it is empty or the
// next one advances, so bubbles collapse. When the receiver stalls, the
// output holds and the pipe fills; after five requests o_in_ready drops until
// the receiver takes one. Reset clears the valid bits and all coefficients to
// zero.
`default_nettype none

module pressure_sensor_compensation_top
    import psc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_req           i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_req               o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_reg_idx          i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data
);

    t_coefs    coefs;
    logic      poly_valid;
    logic      poly_ready;
    t_poly_res poly_data;

    psc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    psc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coefs (coefs),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (poly_valid),
        .i_ready (poly_ready),
        .o_data  (poly_data)
    );

    psc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (poly_valid),
        .o_ready (poly_ready),
        .i_data  (poly_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ tb/pressure_comp_checker.sv @@
// Checker for the pressure compensation block: predicts every result and compares it.
module pressure_comp_checker
    import psc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_req           i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_req          i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  t_reg_idx          i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    t_coefs   coefs;
    t_out_req expected_readings[$];
    int       mismatches;

    assign o_fail_count = mismatches;

    function automatic t_out_req compensate_sample(input t_in_req req, input t_coefs c);
        longint   padc;
        longint   tadc;
        longint   acc;
        longint   top;
        longint   q4;
        longint   kpa;
        t_out_req res;
        padc = longint'(req.pressure_word[WORD_W-1 -: ADC_W]);
        tadc = longint'(req.temperature_word[WORD_W-1 -: ADC_W]);
        // all four terms lined up on 22 fraction bits
        acc = (longint'($signed(c.a0)) <<< A0_SHIFT)
            + ((longint'($signed(c.b1)) * padc) <<< B1_SHIFT)
            + longint'($signed(c.c12[WORD_W-1:2])) * tadc * padc
            + ((longint'($signed(c.b2)) * tadc) <<< B2_SHIFT);
        top = longint'(PCOMP_MAX) <<< FRAC_BITS;
        res.clamped = (acc < 0) || (acc > top);
        if (acc < 0) begin
            q4 = 0;
        end else if (acc > top) begin
            q4 = longint'(PCOMP_MAX) * 16;
        end else begin
            q4 = acc >>> (FRAC_BITS - 4);
        end
        kpa = KPA_LOW * 16 + (q4 * (KPA_HIGH - KPA_LOW) + PCOMP_MAX / 2) / PCOMP_MAX;
        res.pressure_sixteenths_kpa = KPA_W'(kpa);
        res.pcomp_q4 = Q4_W'(q4);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            coefs = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_A0:  coefs.a0  = i_cfg_data;
                    REG_B1:  coefs.b1  = i_cfg_data;
                    REG_B2:  coefs.b2  = i_cfg_data;
                    REG_C12: coefs.c12 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding",
                                              i_out_data));
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out_data.pressure_sixteenths_kpa != want.pressure_sixteenths_kpa)
                        report_mismatch($sformatf("kPa/16 got %0d want %0d",
                            i_out_data.pressure_sixteenths_kpa,
                            want.pressure_sixteenths_kpa));
                    if (i_out_data.pcomp_q4 != want.pcomp_q4)
                        report_mismatch($sformatf("pcomp_q4 got %0d want %0d",
                            i_out_data.pcomp_q4, want.pcomp_q4));
                    if (i_out_data.clamped != want.clamped)
                        report_mismatch($sformatf("clamped got %0b want %0b",
                            i_out_data.clamped, want.clamped));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(compensate_sample(i_in_data, coefs));
        end
        o_pending <= expected_readings.size();
    end

endmodule

@@ tb/tb_pressure_sensor_compensation_top.sv @@
// Testbench top for the pressure compensation block: stimulus, handshakes and verdict.
module tb_pressure_sensor_compensation_top;
    import psc_pkg::*;

    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 115;
    localparam int WATCHDOG_TIME = 4000000;

    logic              i_clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_req           in_data;
    logic              out_valid;
    logic              out_ready;
    t_out_req          out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    t_reg_idx          cfg_index;
    logic [WORD_W-1:0] cfg_data;
    int                fail_count;
    int                pending;

    bit idle_on  = 1'b0;
    bit stall_on = 1'b0;
    bit hold_req = 1'b0;

    pressure_sensor_compensation_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pressure_comp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_TIME);
        $display("pressure_sensor_compensation_top regression: fail");
        $finish;
    end

    // receiver: random stall after each request taken, long hold when asked
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        do @(posedge i_clk); while (!rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (out_ready && out_valid) begin
                stall_left = stall_on ? $urandom_range(0, 4) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
            @(posedge i_clk);
        end
    end

    // called at a clock edge; returns at the edge that takes the request
    task automatic send_req(input logic [WORD_W-1:0] pw, input logic [WORD_W-1:0] tw);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data.pressure_word <= pw;
        in_data.temperature_word <= tw;
        do @(posedge i_clk); while (!(in_valid && in_ready));
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // all four coefficients, starting from a random register
    task automatic load_coefs(input t_coefs c);
        logic [WORD_W-1:0] vals[4];
        int                first;
        t_reg_idx          idx;
        vals = '{c.a0, c.b1, c.b2, c.c12};
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'((first + k) % 4);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[int'(idx)];
            do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_coefs            c;
        logic [WORD_W-1:0] pw;
        logic [WORD_W-1:0] tw;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_A0;
        cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        // coefficients straight out of reset: every sum is exactly zero
        send_req(16'h0000, 16'h0000);
        send_req(16'hFFFF, 16'hFFFF);
        send_req(16'h003F, 16'h003F);
        wait_for_idle();
        // largest positive coefficients: clamps high
        load_coefs('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_req(16'hFFFF, 16'hFFFF);
        send_req(16'h0000, 16'h0000);
        wait_for_idle();
        // most negative coefficients: clamps low
        load_coefs('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_req(16'hFFFF, 16'h0000);
        send_req(16'h0000, 16'hFFFF);
        wait_for_idle();
        // mid range with fraction bits to truncate, c12 low bits set but unused
        load_coefs('{16'h1000, 16'h0001, 16'hFFFF, 16'h0007});
        send_req(16'hFFC0, 16'hFFC0);
        send_req(16'h8000, 16'h4000);
        send_req(16'h1234, 16'hABCD);
        wait_for_idle();
        // sum at exactly 1023, one LSB over and one LSB under
        load_coefs('{16'd8184, 16'h0001, 16'hFFFF, 16'h0000});
        send_req(16'h0000, 16'h0000);
        send_req(16'h0040, 16'h0000);
        send_req(16'h0000, 16'h0040);
        send_req(16'h0040, 16'h0040);
        wait_for_idle();
        // sum just below zero, and just above
        load_coefs('{16'h0000, 16'h0000, 16'hFFFF, 16'h0004});
        send_req(16'h0000, 16'h0040);
        send_req(16'h0040, 16'h0040);
        send_req(16'hFFC0, 16'h0040);
        wait_for_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    c.a0  = 16'($urandom);
                    c.b1  = 16'($urandom);
                    c.b2  = 16'($urandom);
                    c.c12 = 16'($urandom);
                end
                2: begin
                    c.a0  = extreme_word();
                    c.b1  = extreme_word();
                    c.b2  = extreme_word();
                    c.c12 = extreme_word();
                end
                default: begin
                    // keeps most sums inside 0..1023
                    c.a0  = 16'($urandom_range(0, 8184));
                    c.b1  = 16'($urandom_range(0, 8191)) - 16'd4096;
                    c.b2  = 16'($urandom_range(0, 8191)) - 16'd4096;
                    c.c12 = 16'($urandom_range(0, 4095)) - 16'd2048;
                end
            endcase
            idle_on  = (ph > 1) && ($urandom_range(0, 3) != 0);
            stall_on = (ph > 0) && ($urandom_range(0, 3) != 0);
            load_coefs(c);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // receiver holds off while requests keep coming, so the pipe backs up
                if (ph == 1 && i == 30) hold_req = 1'b1;
                if (ph == 2 && i == 50) begin
                    in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
                pw = 16'($urandom);
                tw = 16'($urandom);
                if ($urandom_range(0, 7) == 0)
                    pw[WORD_W-1 -: ADC_W] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
                if ($urandom_range(0, 7) == 0)
                    tw[WORD_W-1 -: ADC_W] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
                send_req(pw, tw);
            end
            wait_for_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("pressure_sensor_compensation_top regression: pass");
        end else begin
            $display("pressure_sensor_compensation_top regression: fail");
        end
        $finish;
    end

endmodule
